FILE: design/fletcher16_report_frame_checker_core_defines.svh
// Assertion helpers shared by the checker modules.
// Each expects clk and arst_n in the scope where it is used.
`ifndef FLETCHER16_REPORT_FRAME_CHECKER_CORE_DEFINES_SVH
`define FLETCHER16_REPORT_FRAME_CHECKER_CORE_DEFINES_SVH

// same-cycle implication
`define FCR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FCR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/fcr_pkg.sv
`timescale 1ns / 1ps
package fcr_pkg;

	localparam int FRAME_BYTES_DEF  = 11;
	localparam int REPORT_BYTES_DEF = 8;
	localparam int QUEUE_DEPTH      = 2;
	localparam int BYTE_W           = 8;
	localparam int REPORT_W         = 64;
	localparam int SEQ_W            = 4;

	localparam logic [BYTE_W-1:0] SUM_INIT  = 8'hFF;
	localparam logic [SEQ_W-1:0]  SEQ_RESET = 4'd8;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} fcr_word_t;

	function automatic logic [BYTE_W-1:0] eac_add(input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > 9'd255) begin
			s = s - 9'd255;
		end
		return s[BYTE_W-1:0];
	endfunction

endpackage

FILE: design/fcr_front.sv
`timescale 1ns / 1ps
`include "fletcher16_report_frame_checker_core_defines.svh"
module fcr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rx_valid,
	output logic                      rx_stall,
	input  logic [fcr_pkg::BYTE_W-1:0] rx_byte,
	input  logic                      link_configured,
	output fcr_pkg::fcr_word_t        word,
	input  logic                      pop
);
	import fcr_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [BYTE_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [NW-1:0]     cnt_q;
	logic              push;

	assign rx_stall   = (cnt_q == NW'(QUEUE_DEPTH));
	assign push       = rx_valid && !rx_stall && link_configured;
	assign word.valid = (cnt_q != '0);
	assign word.data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= rx_byte;
		end
	end

	`FCR_ASSERT_NOW(a_no_underflow, pop, cnt_q != '0, "pop from empty queue")
	`FCR_ASSERT_NOW(a_no_overflow, push, cnt_q != NW'(QUEUE_DEPTH), "push into full queue")
	`FCR_ASSERT_NEXT(a_drop_unconf, rx_valid && !rx_stall && !link_configured && !pop,
		$stable(cnt_q), "dropped word changed queue fill")

endmodule

FILE: design/fcr_back.sv
`timescale 1ns / 1ps
`include "fletcher16_report_frame_checker_core_defines.svh"
module fcr_back #(
	parameter int FRAME_BYTES  = fcr_pkg::FRAME_BYTES_DEF,
	parameter int REPORT_BYTES = fcr_pkg::REPORT_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fcr_pkg::fcr_word_t          word,
	output logic                        pop,
	input  logic [fcr_pkg::SEQ_W-1:0]   seq_index,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        frame_status,
	output logic [fcr_pkg::BYTE_W-1:0]  ack_seq,
	output logic [fcr_pkg::REPORT_W-1:0] report_keys
);
	import fcr_pkg::*;

	localparam int CW = $clog2(FRAME_BYTES + 1);
	localparam int EW = CW + 1;

	logic [CW-1:0]       count_q;
	logic [BYTE_W-1:0]   store_q [FRAME_BYTES];
	logic [BYTE_W-1:0]   sum_a_q;
	logic [BYTE_W-1:0]   sum_b_q;
	logic [BYTE_W-1:0]   sum_a_n;
	logic [BYTE_W-1:0]   sum_b_n;
	logic [REPORT_W-1:0] held_q;
	logic [REPORT_W-1:0] report_n;
	logic                res_valid_q;
	logic                status_q;
	logic [BYTE_W-1:0]   ack_q;
	logic [REPORT_W-1:0] keys_q;
	logic [BYTE_W-1:0]   seq_byte;
	logic [EW-1:0]       seq_ext;
	logic                last;
	logic                good;
	logic                done;

	assign last    = (count_q == CW'(FRAME_BYTES - 1));
	assign pop     = word.valid && (!last || !res_valid_q || !res_stall);
	assign done    = pop && last;
	assign sum_a_n = eac_add(sum_a_q, word.data);
	assign sum_b_n = eac_add(sum_b_q, sum_a_n);
	assign good    = (sum_a_q == store_q[FRAME_BYTES-2]) && (sum_b_q == word.data);
	assign seq_ext = {{(EW-SEQ_W){1'b0}}, seq_index};

	always_comb begin
		seq_byte = '0;
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			if (seq_ext == EW'(i)) begin
				seq_byte = store_q[i];
			end
		end
		if (seq_ext == EW'(FRAME_BYTES - 1)) begin
			seq_byte = word.data;
		end
	end

	always_comb begin
		report_n = '0;
		for (int i = 0; i < REPORT_BYTES; i++) begin
			report_n[8*i +: 8] = store_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_a_q     <= SUM_INIT;
			sum_b_q     <= SUM_INIT;
			held_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (last) begin
					count_q <= '0;
					sum_a_q <= SUM_INIT;
					sum_b_q <= SUM_INIT;
				end else begin
					count_q <= count_q + 1'b1;
					if (count_q < CW'(FRAME_BYTES - 2)) begin
						sum_a_q <= sum_a_n;
						sum_b_q <= sum_b_n;
					end
				end
			end
			if (done && good) begin
				held_q <= report_n;
			end
			if (done) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				if (count_q == CW'(i)) begin
					store_q[i] <= word.data;
				end
			end
		end
		if (done) begin
			status_q <= !good;
			ack_q    <= good ? seq_byte : '0;
			keys_q   <= good ? report_n : held_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_status = status_q;
	assign ack_seq      = ack_q;
	assign report_keys  = keys_q;

	`FCR_ASSERT_NOW(a_count_range, 1'b1, count_q < CW'(FRAME_BYTES), "byte count past frame")
	`FCR_ASSERT_NEXT(a_restart, done, count_q == '0 && sum_a_q == SUM_INIT,
		"frame end did not restart alignment")
	`FCR_ASSERT_NOW(a_bad_ack, res_valid_q && status_q, ack_q == '0,
		"bad frame carries an acknowledge")
	`FCR_ASSERT_NOW(a_no_overwrite, res_valid_q && res_stall, !done,
		"stalled result overwritten")

endmodule

FILE: design/fletcher16_report_frame_checker_core.sv
`timescale 1ns / 1ps
// Fletcher-16 checked report frame receiver.
// Input channel (rx_valid / rx_stall): one serial byte per word with its
// link_configured flag; words with the flag low are taken and dropped.
// Frames are FRAME_BYTES long: report bytes first, the sequence byte at
// seq_index, then the two Fletcher-16 check bytes.
// Result channel (res_valid / res_stall): one word per completed frame with
// frame_status (0 good, 1 bad), ack_seq (sequence byte when good, else 0)
// and report_keys (report held after this frame, byte 0 in the low bits).
// seq_index is written through seq_index_we / seq_index_wdata while idle;
// the user must keep to this, the block does not enforce it. Throughput: one
// byte per cycle, set by the running sum update in the back end, while no
// stalled result holds the flow. res_valid rises once the last byte of its
// frame passes a queue slot, then the result register. When the receiver
// stalls, the result is held; bytes of the next frame keep flowing until its
// last byte, the two-entry queue then fills and rx_stall rises. Reset clears
// alignment, held report and queue, and sets sums to 8'hFF, seq_index to 8.
module fletcher16_report_frame_checker_core #(
	parameter int FRAME_BYTES  = fcr_pkg::FRAME_BYTES_DEF,
	parameter int REPORT_BYTES = fcr_pkg::REPORT_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rx_valid,
	output logic                         rx_stall,
	input  logic [fcr_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                         link_configured,
	input  logic                         seq_index_we,
	input  logic [fcr_pkg::SEQ_W-1:0]    seq_index_wdata,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         frame_status,
	output logic [fcr_pkg::BYTE_W-1:0]   ack_seq,
	output logic [fcr_pkg::REPORT_W-1:0] report_keys
);
	import fcr_pkg::*;

	logic [SEQ_W-1:0] seq_index_q;
	fcr_word_t        word;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_index_q <= SEQ_RESET;
		end else if (seq_index_we) begin
			seq_index_q <= seq_index_wdata;
		end
	end

	fcr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_valid        (rx_valid),
		.rx_stall        (rx_stall),
		.rx_byte         (rx_byte),
		.link_configured (link_configured),
		.word            (word),
		.pop             (pop)
	);

	fcr_back #(
		.FRAME_BYTES  (FRAME_BYTES),
		.REPORT_BYTES (REPORT_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.word         (word),
		.pop          (pop),
		.seq_index    (seq_index_q),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.frame_status (frame_status),
		.ack_seq      (ack_seq),
		.report_keys  (report_keys)
	);

endmodule
